/* hw/rtl/mobc_pkg.sv */
// ----------------------------------------------------------------------------
// mobc_pkg - multicart outer bank controller package
// Variant codes, bank window types and the per-variant reset table.
// ----------------------------------------------------------------------------
package mobc_pkg;

	localparam int unsigned OffsW = 22;

	localparam logic [2:0] VAR_M37  = 3'd0;
	localparam logic [2:0] VAR_M44  = 3'd1;
	localparam logic [2:0] VAR_M45  = 3'd2;
	localparam logic [2:0] VAR_M47  = 3'd3;
	localparam logic [2:0] VAR_M49  = 3'd4;
	localparam logic [2:0] VAR_M52  = 3'd5;
	localparam logic [2:0] VAR_M205 = 3'd6;
	localparam logic [2:0] VAR_NONE = 3'd7;

	localparam logic [15:0] ADDR_M44_SEL = 16'hA001;

	localparam logic [OffsW-1:0] MASK_64K  = 22'h00FFFF;
	localparam logic [OffsW-1:0] MASK_128K = 22'h01FFFF;
	localparam logic [OffsW-1:0] MASK_256K = 22'h03FFFF;
	localparam logic [OffsW-1:0] BASE_128K = 22'h020000;
	localparam logic [OffsW-1:0] BASE_M45  = 22'h060000;

	localparam logic [2:0] CFG_IDX_VARIANT = 3'd0;

	typedef struct packed {
		logic [OffsW-1:0] prg_base;
		logic [OffsW-1:0] prg_mask;
		logic [OffsW-1:0] chr_base;
		logic [OffsW-1:0] chr_mask;
	} banks_t;

	typedef struct packed {
		banks_t           banks;
		logic             forward_to_core;
		logic             direct_rom;
		logic [OffsW-1:0] rom_offset;
		logic [7:0]       read_data;
	} result_t;

	function automatic banks_t mk_banks(logic [OffsW-1:0] pb, logic [OffsW-1:0] pm,
	                                    logic [OffsW-1:0] cb, logic [OffsW-1:0] cm);
		banks_t b;
		b.prg_base = pb;
		b.prg_mask = pm;
		b.chr_base = cb;
		b.chr_mask = cm;
		return b;
	endfunction

	function automatic banks_t init_banks(logic [2:0] v);
		banks_t b;
		case (v)
			VAR_M37:                    b = mk_banks('0, MASK_64K, '0, MASK_128K);
			VAR_M44, VAR_M47, VAR_M49:  b = mk_banks('0, MASK_128K, '0, MASK_128K);
			VAR_M45:                    b = mk_banks(BASE_M45, MASK_128K, '0, MASK_128K);
			VAR_M52, VAR_M205:          b = mk_banks('0, MASK_256K, '0, MASK_256K);
			default:                    b = mk_banks('0, MASK_64K, '0, MASK_128K);
		endcase
		return b;
	endfunction

endpackage

/* hw/rtl/multicart_outer_bank_controller_top.sv */
// ----------------------------------------------------------------------------
// multicart_outer_bank_controller_top - outer bank logic for multicart boards
// Tracks the outer PRG/CHR windows of seven board variants beside a bank core
// and tells, per bus access, whether the core takes it or ROM answers direct.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | in_valid / in_ready       | opcode, address, data
//  result   | out_valid / out_ready     | prg/chr base+mask, forward_to_core,
//           |                           | direct_rom, rom_offset, read_data
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata (variant)
//
//  One access per cycle while in_ready is high: each is decoded and the board
//  state updated as it transfers; its result lands in the output register.
//  in_ready drops only while a result is held and out_ready is low.
//  Reset (arst_n low) loads the m37 defaults and empties the output register.
//  A variant write (not VAR_NONE) loads that variant's banks, clears the rest.
// ----------------------------------------------------------------------------
module multicart_outer_bank_controller_top
	import mobc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// access channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             opcode,
	input  logic [15:0]      address,
	input  logic [7:0]       data,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [OffsW-1:0] prg_base,
	output logic [OffsW-1:0] prg_mask,
	output logic [OffsW-1:0] chr_base,
	output logic [OffsW-1:0] chr_mask,
	output logic             forward_to_core,
	output logic             direct_rom,
	output logic [OffsW-1:0] rom_offset,
	output logic [7:0]       read_data
);

	logic [2:0] variant_q;
	banks_t     banks_q;
	logic       lock_q;
	logic [1:0] cycle_q;
	logic       mode_q;
	logic [1:0] sel_q;

	banks_t     banks_d;
	logic       lock_d;
	logic [1:0] cycle_d;
	logic       mode_d;
	logic [1:0] sel_d;

	result_t    res_d;
	result_t    res_q;
	logic       out_valid_q;

	logic       in_xfer;
	logic       cfg_wr;
	logic       win;
	logic       hi;
	logic       fwd_wr;
	logic [2:0] v3;
	logic [1:0] v2;
	logic [2:0] c3;
	logic [8:0] chr_span;
	logic [6:0] prg_span;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready && (paddr == CFG_IDX_VARIANT)
	                  && (pwdata[2:0] != VAR_NONE);
	assign prdata   = (paddr == CFG_IDX_VARIANT) ? {29'd0, variant_q} : 32'd0;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer  = in_valid && in_ready;

	assign win = (address[15:13] == 3'b011);
	assign hi  = address[15];
	assign v3  = data[2:0];
	assign v2  = data[1:0];
	assign c3  = {data[5], data[2], data[4]};

	assign chr_span = 9'(8'hFF >> (~data[3:0])) + 9'd1;
	assign prg_span = {1'b0, ~data[5:0]} + 7'd1;

	// next board state and result for the access on the input
	always_comb begin
		banks_d = banks_q;
		lock_d  = lock_q;
		cycle_d = cycle_q;
		mode_d  = mode_q;
		sel_d   = sel_q;
		fwd_wr  = hi;

		if (!opcode) begin
			case (variant_q)
				VAR_M37: begin
					if (win) begin
						fwd_wr = 1'b0;
						if (v3 < 3'd3)
							banks_d = mk_banks('0, MASK_64K, '0, MASK_128K);
						else if (v3 == 3'd3)
							banks_d = mk_banks(22'h010000, MASK_64K, '0, MASK_128K);
						else if (v3 != 3'd7)
							banks_d = mk_banks(BASE_128K, MASK_128K, BASE_128K, MASK_128K);
						else
							banks_d = mk_banks(22'h030000, MASK_64K, BASE_128K, MASK_128K);
					end
				end
				VAR_M44: begin
					fwd_wr = (address != ADDR_M44_SEL);
					if (address == ADDR_M44_SEL) begin
						if (v3 >= 3'd6)
							banks_d = mk_banks(22'h0C0000, MASK_256K, 22'h0C0000, MASK_256K);
						else
							banks_d = mk_banks({2'd0, v3, 17'd0}, MASK_128K,
							                   {2'd0, v3, 17'd0}, MASK_128K);
					end
				end
				VAR_M45: begin
					if (win) begin
						fwd_wr = lock_q;
						if (!lock_q) begin
							case (cycle_q)
								2'd0: banks_d.chr_base = {banks_q.chr_base[21:18], data, 10'd0};
								2'd1: banks_d.prg_base = {1'b0, data, 13'd0};
								2'd2: begin
									banks_d.chr_mask = {3'd0, chr_span, 10'd0} - 22'd1;
									banks_d.chr_base = {data[7:4], banks_q.chr_base[17:0]};
								end
								default: begin
									lock_d           = data[6];
									banks_d.prg_mask = {2'd0, prg_span, 13'd0} - 22'd1;
								end
							endcase
							cycle_d = cycle_q + 2'd1;
						end
					end
				end
				VAR_M47: begin
					if (win) begin
						fwd_wr = 1'b0;
						// even nonzero byte: hold the bases
						if (data == 8'd0) begin
							banks_d.prg_base = '0;
							banks_d.chr_base = '0;
						end else if (data[0]) begin
							banks_d.prg_base = BASE_128K;
							banks_d.chr_base = BASE_128K;
						end
					end
				end
				VAR_M49: begin
					if (win) begin
						fwd_wr = 1'b0;
						if (!lock_q) begin
							banks_d = mk_banks({3'd0, data[7:6], 17'd0}, MASK_128K,
							                   {3'd0, data[7:6], 17'd0}, MASK_128K);
							mode_d  = data[0];
							sel_d   = data[5:4];
						end
					end else if (address[15:13] == 3'b101 && address[0]) begin
						lock_d = !data[7];
					end
				end
				VAR_M52: begin
					if (win) begin
						fwd_wr = lock_q;
						if (!lock_q) begin
							if (data[3])
								{banks_d.prg_mask, banks_d.prg_base} =
									{MASK_128K, 2'd0, v3, 17'd0};
							else
								{banks_d.prg_mask, banks_d.prg_base} =
									{MASK_256K, 2'd0, v3[2:1], 18'd0};
							if (data[6])
								{banks_d.chr_mask, banks_d.chr_base} =
									{MASK_128K, 2'd0, c3, 17'd0};
							else
								{banks_d.chr_mask, banks_d.chr_base} =
									{MASK_256K, 2'd0, c3[2:1], 18'd0};
							lock_d = data[7];
						end
					end
				end
				default: begin
					if (win) begin
						fwd_wr = 1'b0;
						if (!v2[1])
							banks_d = mk_banks({3'd0, v2, 17'd0}, MASK_256K,
							                   {3'd0, v2, 17'd0}, MASK_256K);
						else
							banks_d = mk_banks({3'd0, v2, 17'd0}, MASK_128K,
							                   {3'd0, v2, 17'd0}, MASK_128K);
					end
				end
			endcase
		end

		res_d.banks      = banks_d;
		res_d.direct_rom = 1'b0;
		res_d.rom_offset = '0;
		res_d.read_data  = '0;
		if (!opcode) begin
			res_d.forward_to_core = fwd_wr;
		end else begin
			res_d.read_data = hi ? 8'd0 : data;
			if (variant_q == VAR_M49) begin
				res_d.forward_to_core = hi && mode_q;
				if (hi && !mode_q) begin
					res_d.direct_rom = 1'b1;
					res_d.rom_offset = {7'd0, address[14:0]} | {5'd0, sel_q, 15'd0}
					                   | banks_q.prg_base;
				end
			end else begin
				res_d.forward_to_core = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= VAR_M37;
			banks_q   <= init_banks(VAR_M37);
			lock_q    <= 1'b0;
			cycle_q   <= 2'd0;
			mode_q    <= 1'b0;
			sel_q     <= 2'd0;
		end else if (cfg_wr) begin
			variant_q <= pwdata[2:0];
			banks_q   <= init_banks(pwdata[2:0]);
			lock_q    <= 1'b0;
			cycle_q   <= 2'd0;
			mode_q    <= 1'b0;
			sel_q     <= 2'd0;
		end else if (in_xfer) begin
			banks_q <= banks_d;
			lock_q  <= lock_d;
			cycle_q <= cycle_d;
			mode_q  <= mode_d;
			sel_q   <= sel_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// hold the result until its transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_q <= res_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign prg_base        = res_q.banks.prg_base;
	assign prg_mask        = res_q.banks.prg_mask;
	assign chr_base        = res_q.banks.chr_base;
	assign chr_mask        = res_q.banks.chr_mask;
	assign forward_to_core = res_q.forward_to_core;
	assign direct_rom      = res_q.direct_rom;
	assign rom_offset      = res_q.rom_offset;
	assign read_data       = res_q.read_data;

endmodule
